// File: rtl/core/rpy_pkg.sv
// Shared widths, payload structs and the arctangent table for the quaternion to
// roll/pitch/yaw converter. No dependencies.
package rpy_pkg;

  localparam int QUAT_FRAC_BITS = 14;
  localparam int ANGLE_BITS     = 16;
  localparam int CORDIC_STEPS   = 16;

  localparam int Q_W        = 16;
  localparam int PROD_W     = 2 * Q_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int MAG_W      = SUM_W;
  localparam int AS_W       = 2 * QUAT_FRAC_BITS;
  localparam int ROOT_W     = AS_W + 1;
  localparam int V_W        = 2 * AS_W + 1;
  localparam int TRIAL_W    = V_W + 1;
  localparam int NORM_BITS  = 40;
  localparam int CX_W       = NORM_BITS + 3;
  localparam int ANG_FRAC   = 60;
  localparam int ANG_W      = ANG_FRAC + 2;
  localparam int ACC_W      = 64;
  localparam int TAB_LEN    = 32;
  localparam int CORDIC_N   = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
  localparam int NORM_N     = 6;
  localparam int IDX_W      = 5;
  localparam int NIDX_W     = 3;
  localparam int NUM_LANES  = 3;
  localparam int ROUND_SH   = ANG_FRAC - (ANGLE_BITS - 1);
  localparam int IN_DATA_W  = 4 * Q_W;
  localparam int OUT_DATA_W = ((3 * ANGLE_BITS + 7) / 8) * 8;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  localparam logic [63:0] INV_PI_Q64 = 64'h517CC1B727220A95;

  // atan2 operand magnitudes and quadrant signs
  typedef struct packed {
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic             neg_x;
    logic             neg_y;
  } opnd_t;

  // square-root stage payload; roll and yaw operands ride along
  typedef struct packed {
    logic [V_W-1:0]    rem;
    logic [ROOT_W-1:0] root;
    logic [AS_W-1:0]   as;
    logic              sgn;
    logic              lock;
    opnd_t             roll;
    opnd_t             yaw;
  } sqrt_t;

  typedef struct packed {
    logic [NORM_BITS-1:0] x;
    logic [NORM_BITS-1:0] y;
    logic                 zero;
    logic                 neg_x;
    logic                 neg_y;
  } nvec_t;

  typedef struct packed {
    nvec_t [NUM_LANES-1:0] ln;
    logic                  lock;
  } norm_t;

  typedef struct packed {
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
    logic                    zero;
    logic                    neg_x;
    logic                    neg_y;
  } cvec_t;

  typedef struct packed {
    cvec_t [NUM_LANES-1:0] ln;
    logic                  lock;
  } cord_t;

  typedef logic [63:0] atan_tab_t [TAB_LEN];

  // restoring long division, elaboration only
  function automatic logic [63:0] long_div(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) with pi = 2^60, from a Q60 radian series times 1/pi
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [127:0] prod;
    sum = '0;
    if (i == 0) begin
      return 64'd1 << (ANG_FRAC - 2);
    end
    for (int k = 0; k < 31; k++) begin
      if (i * (2 * k + 1) <= 60) begin
        term = long_div(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    prod = {64'd0, sum} * {64'd0, INV_PI_Q64};
    return prod[127:64];
  endfunction

  function automatic atan_tab_t build_tab();
    atan_tab_t t;
    for (int i = 0; i < TAB_LEN; i++) begin
      t[i] = atan_entry(i);
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_tab();

endpackage

// File: rtl/core/quaternion_to_euler_rpy.sv
// Top level of the quaternion to roll/pitch/yaw converter: front-end products,
// square-root, normalizer and CORDIC cell chains, quadrant fix and rounding.
// Depends on rpy_pkg, rpy_sqrt_cell, rpy_norm_cell, rpy_cordic_cell.
//
//  channel  dir  bits  contents
//  s_*      in   64    qx, qy, qz, qw (signed Q2.14)
//  m_*      out  48+1  roll, pitch, yaw binary angles; tuser = gimbal_lock
//
// Throughput is one transaction per cycle while m_tready is high. The pipeline
// holds 5 front-end stages, 29 square-root cells (one root bit each), 6
// normalizer cells, CORDIC_N rotation cells (16) and 2 finishing stages.
// rst is synchronous and clears only the valid bits of the stages.
// Every stage holds its transaction while the next one is full and stalled, so a
// stall at m_tready backs up stage by stage and empty stages keep filling.
module quaternion_to_euler_rpy
  import rpy_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // qx[15:0], qy[31:16], qz[47:32], qw[63:48]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // roll[15:0], pitch[31:16], yaw[47:32]
  output logic                  m_tuser    // gimbal_lock
);

  localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1) << (2 * QUAT_FRAC_BITS);

  // ---------------- stage 1: products ----------------
  logic signed [Q_W-1:0]    qx, qy, qz, qw;
  logic                     v1, r1;
  logic signed [PROD_W-1:0] p_wy, p_zx, p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz;

  assign qx = signed'(s_tdata[Q_W-1:0]);
  assign qy = signed'(s_tdata[2*Q_W-1:Q_W]);
  assign qz = signed'(s_tdata[3*Q_W-1:2*Q_W]);
  assign qw = signed'(s_tdata[4*Q_W-1:3*Q_W]);

  logic v2, r2;
  assign r1       = !v1 || r2;
  assign s_tready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && s_tvalid) begin
      p_wy <= qw * qy;
      p_zx <= qz * qx;
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
    end
  end

  // ---------------- stage 2: sums ----------------
  logic signed [SUM_W-1:0] sinp, rn, rd, yn, yd;
  logic                    v3, r3;

  function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
    return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  assign r2 = !v2 || r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      sinp <= (ext(p_wy) - ext(p_zx)) <<< 1;
      rn   <= (ext(p_wx) + ext(p_yz)) <<< 1;
      rd   <= ONE_S - ((ext(p_xx) + ext(p_yy)) <<< 1);
      yn   <= (ext(p_wz) + ext(p_xy)) <<< 1;
      yd   <= ONE_S - ((ext(p_yy) + ext(p_zz)) <<< 1);
    end
  end

  // ---------------- stage 3: magnitudes, lock detect ----------------
  logic [AS_W-1:0] p3_as;
  logic            p3_lock, p3_sgn;
  opnd_t           p3_roll, p3_yaw;
  logic            v4, r4;

  function automatic logic [MAG_W-1:0] mag(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  assign r3 = !v3 || r4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      p3_as         <= AS_W'(mag(sinp));
      p3_lock       <= (sinp >= ONE_S) || (sinp <= -ONE_S);
      p3_sgn        <= sinp[SUM_W-1];
      p3_roll.mx    <= mag(rd);
      p3_roll.my    <= mag(rn);
      p3_roll.neg_x <= rd[SUM_W-1];
      p3_roll.neg_y <= rn[SUM_W-1];
      p3_yaw.mx     <= mag(yd);
      p3_yaw.my     <= mag(yn);
      p3_yaw.neg_x  <= yd[SUM_W-1];
      p3_yaw.neg_y  <= yn[SUM_W-1];
    end
  end

  // ---------------- stage 4: sinp squared ----------------
  logic [2*AS_W-1:0] p4_sq;
  logic [AS_W-1:0]   p4_as;
  logic              p4_lock, p4_sgn;
  opnd_t             p4_roll, p4_yaw;
  logic              v5, r5;

  assign r4 = !v4 || r5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (r4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      p4_sq   <= p3_as * p3_as;
      p4_as   <= p3_as;
      p4_lock <= p3_lock;
      p4_sgn  <= p3_sgn;
      p4_roll <= p3_roll;
      p4_yaw  <= p3_yaw;
    end
  end

  // ---------------- stage 5: radicand 1 - sinp^2 ----------------
  sqrt_t p5;
  logic  sq_in_ready [ROOT_W+1];
  logic  sq_valid    [ROOT_W+1];
  sqrt_t sq_data     [ROOT_W+1];

  assign r5 = !v5 || sq_in_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (r5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r5 && v4) begin
      p5.rem  <= (V_W'(1) << (2 * AS_W)) - {1'b0, p4_sq};
      p5.root <= '0;
      p5.as   <= p4_as;
      p5.sgn  <= p4_sgn;
      p5.lock <= p4_lock;
      p5.roll <= p4_roll;
      p5.yaw  <= p4_yaw;
    end
  end

  // ---------------- square-root chain: one root bit per cell, MSB first ----------------
  assign sq_valid[0] = v5;
  assign sq_data[0]  = p5;

  logic nm_in_ready [NORM_N+1];
  logic nm_valid    [NORM_N+1];
  norm_t nm_data    [NORM_N+1];

  assign sq_in_ready[ROOT_W] = nm_in_ready[0];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    rpy_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (IDX_W'(ROOT_W - 1 - k)),
      .in_valid  (sq_valid[k]),
      .in_ready  (sq_in_ready[k]),
      .in_data   (sq_data[k]),
      .out_valid (sq_valid[k+1]),
      .out_ready (sq_in_ready[k+1]),
      .out_data  (sq_data[k+1])
    );
  end

  // ---------------- lane build: place operands in the 40-bit field ----------------
  sqrt_t sq_out;
  norm_t nm_first;

  assign sq_out = sq_data[ROOT_W];

  always_comb begin
    nm_first.lock                = sq_out.lock;
    nm_first.ln[LANE_ROLL].x     = NORM_BITS'(sq_out.roll.mx);
    nm_first.ln[LANE_ROLL].y     = NORM_BITS'(sq_out.roll.my);
    nm_first.ln[LANE_ROLL].zero  = (sq_out.roll.mx == '0) && (sq_out.roll.my == '0);
    nm_first.ln[LANE_ROLL].neg_x = sq_out.roll.neg_x;
    nm_first.ln[LANE_ROLL].neg_y = sq_out.roll.neg_y;
    nm_first.ln[LANE_YAW].x      = NORM_BITS'(sq_out.yaw.mx);
    nm_first.ln[LANE_YAW].y      = NORM_BITS'(sq_out.yaw.my);
    nm_first.ln[LANE_YAW].zero   = (sq_out.yaw.mx == '0) && (sq_out.yaw.my == '0);
    nm_first.ln[LANE_YAW].neg_x  = sq_out.yaw.neg_x;
    nm_first.ln[LANE_YAW].neg_y  = sq_out.yaw.neg_y;
    // pitch is asin: atan2(sinp, sqrt(1 - sinp^2)), sign applied at the end
    nm_first.ln[LANE_PITCH].x     = NORM_BITS'(sq_out.root);
    nm_first.ln[LANE_PITCH].y     = NORM_BITS'(sq_out.as);
    nm_first.ln[LANE_PITCH].zero  = (sq_out.root == '0) && (sq_out.as == '0);
    nm_first.ln[LANE_PITCH].neg_x = 1'b0;
    nm_first.ln[LANE_PITCH].neg_y = sq_out.sgn;
  end

  assign nm_valid[0] = sq_valid[ROOT_W];
  assign nm_data[0]  = nm_first;

  // ---------------- normalizer chain: shifts of 32, 16, 8, 4, 2, 1 ----------------
  logic  co_in_ready [CORDIC_N+1];
  logic  co_valid    [CORDIC_N+1];
  cord_t co_data     [CORDIC_N+1];

  assign nm_in_ready[NORM_N] = co_in_ready[0];

  for (genvar k = 0; k < NORM_N; k++) begin : g_norm
    rpy_norm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (NIDX_W'(k)),
      .in_valid  (nm_valid[k]),
      .in_ready  (nm_in_ready[k]),
      .in_data   (nm_data[k]),
      .out_valid (nm_valid[k+1]),
      .out_ready (nm_in_ready[k+1]),
      .out_data  (nm_data[k+1])
    );
  end

  // ---------------- CORDIC chain ----------------
  norm_t nm_out;
  cord_t co_first;

  assign nm_out = nm_data[NORM_N];

  always_comb begin
    co_first.lock = nm_out.lock;
    for (int l = 0; l < NUM_LANES; l++) begin
      co_first.ln[l].x     = signed'(CX_W'(nm_out.ln[l].x));
      co_first.ln[l].y     = signed'(CX_W'(nm_out.ln[l].y));
      co_first.ln[l].z     = '0;
      co_first.ln[l].zero  = nm_out.ln[l].zero;
      co_first.ln[l].neg_x = nm_out.ln[l].neg_x;
      co_first.ln[l].neg_y = nm_out.ln[l].neg_y;
    end
  end

  assign co_valid[0] = nm_valid[NORM_N];
  assign co_data[0]  = co_first;

  logic vf1, rf1;
  assign co_in_ready[CORDIC_N] = rf1;

  for (genvar k = 0; k < CORDIC_N; k++) begin : g_cordic
    rpy_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (IDX_W'(k)),
      .in_valid  (co_valid[k]),
      .in_ready  (co_in_ready[k]),
      .in_data   (co_data[k]),
      .out_valid (co_valid[k+1]),
      .out_ready (co_in_ready[k+1]),
      .out_data  (co_data[k+1])
    );
  end

  // ---------------- finish 1: quadrant fix ----------------
  // x < 0 maps a to pi - a, y < 0 negates; folded into one add of +-z and a constant
  cord_t                   co_out;
  logic signed [ACC_W-1:0] f1_ang [NUM_LANES];
  logic signed [ACC_W-1:0] f1_ang_next [NUM_LANES];
  logic signed [ACC_W-1:0] z64, kst;
  logic                    f1_lock, f1_sgn;
  logic                    vf2, rf2;

  assign co_out = co_data[CORDIC_N];
  assign rf1    = !vf1 || rf2;

  always_comb begin
    z64 = '0;
    kst = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      z64 = {{(ACC_W-ANG_W){co_out.ln[l].z[ANG_W-1]}}, co_out.ln[l].z};
      if (co_out.ln[l].neg_x) begin
        kst = co_out.ln[l].neg_y ? -(ACC_W'(1) <<< ANG_FRAC) : (ACC_W'(1) <<< ANG_FRAC);
      end else begin
        kst = '0;
      end
      if (co_out.ln[l].zero) begin
        f1_ang_next[l] = '0;
      end else if (co_out.ln[l].neg_x ^ co_out.ln[l].neg_y) begin
        f1_ang_next[l] = ~z64 + kst + ACC_W'(1);
      end else begin
        f1_ang_next[l] = z64 + kst;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf1 <= 1'b0;
    end else if (rf1) begin
      vf1 <= co_valid[CORDIC_N];
    end
  end

  always_ff @(posedge clk) begin
    if (rf1 && co_valid[CORDIC_N]) begin
      f1_ang  <= f1_ang_next;
      f1_lock <= co_out.lock;
      f1_sgn  <= co_out.ln[LANE_PITCH].neg_y;
    end
  end

  // ---------------- finish 2: round half up, wrap, output register ----------------
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (ROUND_SH - 1);
  localparam logic [ANGLE_BITS-1:0]   HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic signed [ACC_W-1:0]  rsum [NUM_LANES];
  logic [ANGLE_BITS-1:0]    code [NUM_LANES];
  logic [ANGLE_BITS-1:0]    pitch_code;
  logic [OUT_DATA_W-1:0]    out_data;
  logic                     out_lock;

  assign rf2 = !vf2 || m_tready;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      rsum[l] = (f1_ang[l] + RND) >>> ROUND_SH;
      code[l] = rsum[l][ANGLE_BITS-1:0];
    end
    // gimbal lock: pitch pinned to +-pi/2 with the sign of sinp
    if (f1_lock) begin
      pitch_code = f1_sgn ? (~HALF + ANGLE_BITS'(1)) : HALF;
    end else begin
      pitch_code = code[LANE_PITCH];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf2 <= 1'b0;
    end else if (rf2) begin
      vf2 <= vf1;
    end
  end

  always_ff @(posedge clk) begin
    if (rf2 && vf1) begin
      out_data <= OUT_DATA_W'({code[LANE_YAW], pitch_code, code[LANE_ROLL]});
      out_lock <= f1_lock;
    end
  end

  assign m_tvalid = vf2;
  assign m_tdata  = out_data;
  assign m_tuser  = out_lock;

endmodule

// File: rtl/core/rpy_sqrt_cell.sv
// One result bit of the pipelined integer square root (remainder form).
// Depends on rpy_pkg.
module rpy_sqrt_cell
  import rpy_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  logic             in_valid,
  output logic             in_ready,
  input  sqrt_t            in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sqrt_t            out_data
);

  sqrt_t              data_next;
  logic [TRIAL_W-1:0] trial;
  logic [5:0]         sh1;
  logic [5:0]         sh2;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next = in_data;
    sh1   = {1'b0, idx} + 6'd1;
    sh2   = {idx, 1'b0};
    trial = ({{(TRIAL_W-ROOT_W){1'b0}}, in_data.root} << sh1)
          + ({{(TRIAL_W-1){1'b0}}, 1'b1} << sh2);
    // keep the bit when (root + 2^b)^2 still fits under the radicand
    if ({1'b0, in_data.rem} >= trial) begin
      data_next.rem  = V_W'({1'b0, in_data.rem} - trial);
      data_next.root = in_data.root | (ROOT_W'(1) << idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/core/rpy_norm_cell.sv
// One binary step of the operand normalizer, applied to all three lanes.
// Depends on rpy_pkg.
module rpy_norm_cell
  import rpy_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [NIDX_W-1:0] idx,
  input  logic              in_valid,
  output logic              in_ready,
  input  norm_t             in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output norm_t             out_data
);

  norm_t                data_next;
  logic [5:0]           amt;
  logic [NORM_BITS-1:0] orv;

  assign in_ready = !out_valid || out_ready;
  assign amt      = 6'd1 << (NIDX_W'(NORM_N - 1) - idx);

  always_comb begin
    data_next = in_data;
    orv       = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      orv = in_data.ln[l].x | in_data.ln[l].y;
      // shift when the top amt bits of the larger operand are clear
      if ((orv >> (6'(NORM_BITS) - amt)) == '0) begin
        data_next.ln[l].x = in_data.ln[l].x << amt;
        data_next.ln[l].y = in_data.ln[l].y << amt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/core/rpy_cordic_cell.sv
// One vectoring CORDIC micro-rotation on all three lanes.
// Depends on rpy_pkg (arctangent table).
module rpy_cordic_cell
  import rpy_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  logic             in_valid,
  output logic             in_ready,
  input  cord_t            in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cord_t            out_data
);

  cord_t                   data_next;
  logic signed [ANG_W-1:0] tab;
  logic signed [CX_W-1:0]  dx;
  logic signed [CX_W-1:0]  dy;

  assign in_ready = !out_valid || out_ready;
  assign tab      = signed'(ATAN_TAB[idx][ANG_W-1:0]);

  always_comb begin
    data_next = in_data;
    dx = '0;
    dy = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      dx = in_data.ln[l].y >>> idx;
      dy = in_data.ln[l].x >>> idx;
      if (!in_data.ln[l].y[CX_W-1]) begin
        data_next.ln[l].x = in_data.ln[l].x + dx;
        data_next.ln[l].y = in_data.ln[l].y - dy;
        data_next.ln[l].z = in_data.ln[l].z + tab;
      end else begin
        data_next.ln[l].x = in_data.ln[l].x - dx;
        data_next.ln[l].y = in_data.ln[l].y + dy;
        data_next.ln[l].z = in_data.ln[l].z - tab;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
